// ===== hw/rtl/idte_pkg.sv =====
// Package for the index tuple delta encoder: payload structs, the plan entry
// passed from front to back, the back sequencer states and the code, kind and mode constants.
// No dependencies.
package idte_pkg;

  localparam logic [7:0] CODE_MARKER    = 8'd124;
  localparam logic [7:0] CODE_STEP_ZERO = 8'd125;
  localparam logic [7:0] CODE_STEP_ONE  = 8'd126;
  localparam logic [7:0] CODE_ESCAPE    = 8'd127;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  localparam logic MODE_PLAIN  = 1'b0;
  localparam logic MODE_TAGGED = 1'b1;

  typedef struct packed {
    logic               first_of_vector;
    logic signed [31:0] node_id;
    logic signed [31:0] batch_n;
    logic signed [31:0] time_t;
    logic signed [31:0] extra_x;
  } in_data_t;

  typedef struct packed {
    logic               out_kind;
    logic [7:0]         code_byte;
    logic signed [31:0] word_value;
    logic               last_result;
  } out_data_t;

  // One classified tuple: what the back has to send for it.
  typedef struct packed {
    logic        marker;
    logic        escape;
    logic [7:0]  code;
    logic [31:0] node;
    logic [31:0] n;
    logic [31:0] t;
    logic [31:0] x;
  } plan_t;

  typedef enum logic [2:0] {
    BK_START,
    BK_MARK,
    BK_NODE,
    BK_CODE,
    BK_N,
    BK_T,
    BK_X
  } bk_step_t;

endpackage

// ===== hw/rtl/idte_front.sv =====
// Front of the encoder: holds the mode register and the previous tuple and
// classifies each accepted tuple into a plan entry. Depends on idte_pkg.
module idte_front import idte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_data_t in_data,
  output logic     in_stall,
  input  logic     cfg_valid,
  input  logic     cfg_data,
  output logic     cfg_ready,
  output logic     q_wr,
  output plan_t    q_data,
  input  logic     q_full
);

  logic        mode_r;
  logic [31:0] prev_node_r, prev_n_r, prev_t_r, prev_x_r;

  logic               accept;
  logic signed [31:0] n_s, t_s, x_s;
  logic signed [32:0] dt, dn;
  logic               tag_mode, marker, in_range, byte_ok, step_ok;
  logic [7:0]         byte_code, step_code;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;
  assign q_wr      = accept;

  assign n_s = in_data.batch_n;
  assign t_s = in_data.time_t;
  assign x_s = in_data.extra_x;

  // Differences at 33 bits so they never wrap.
  assign dt = {t_s[31], t_s} - {prev_t_r[31], prev_t_r};
  assign dn = {n_s[31], n_s} - {prev_n_r[31], prev_n_r};

  always_comb begin
    tag_mode = (mode_r == MODE_TAGGED);
    marker = tag_mode & (in_data.first_of_vector | (in_data.node_id != prev_node_r));
    if (tag_mode) begin
      in_range = (dt > -33'sd124) && (dt < 33'sd124);
    end else begin
      in_range = (dt > -33'sd125) && (dt < 33'sd125);
    end
    if (in_data.first_of_vector) begin
      byte_ok   = (n_s == 32'sd0) && (x_s == 32'sd0) &&
                  (t_s > -32'sd125) && (t_s < 32'sd125);
      byte_code = t_s[7:0];
      step_ok   = tag_mode && (t_s == 32'sd0) && (x_s == 32'sd0) &&
                  ((n_s == 32'sd0) || (n_s == 32'sd1));
      step_code = n_s[0] ? CODE_STEP_ONE : CODE_STEP_ZERO;
    end else begin
      byte_ok   = (n_s == prev_n_r) && (x_s == prev_x_r) && in_range;
      byte_code = dt[7:0];
      step_ok   = tag_mode && (t_s == prev_t_r) && (x_s == prev_x_r) &&
                  ((dn == 33'sd0) || (dn == 33'sd1));
      step_code = dn[0] ? CODE_STEP_ONE : CODE_STEP_ZERO;
    end
    q_data.marker = marker;
    q_data.escape = ~byte_ok & ~step_ok;
    if (byte_ok) begin
      q_data.code = byte_code;
    end else if (step_ok) begin
      q_data.code = step_code;
    end else begin
      q_data.code = CODE_ESCAPE;
    end
    q_data.node = in_data.node_id;
    q_data.n    = in_data.batch_n;
    q_data.t    = in_data.time_t;
    q_data.x    = in_data.extra_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TAGGED;
      prev_node_r <= '0;
      prev_n_r    <= '0;
      prev_t_r    <= '0;
      prev_x_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (accept) begin
        prev_node_r <= in_data.node_id;
        prev_n_r    <= in_data.batch_n;
        prev_t_r    <= in_data.time_t;
        prev_x_r    <= in_data.extra_x;
      end
    end
  end

endmodule

// ===== hw/rtl/idte_queue.sv =====
// Two-entry plan queue between the front and the back of the encoder.
// Depends on idte_pkg.
module idte_queue import idte_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  plan_t wr_data,
  output logic  full,
  output logic  rd_valid,
  output plan_t rd_data,
  input  logic  rd_pop
);

  plan_t      entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!wr_en && rd_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/idte_back.sv =====
// Back of the encoder: steps through the results of the plan at the queue
// head and drives the output register. Depends on idte_pkg.
module idte_back import idte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  plan_t     q_data,
  output logic      q_pop,
  output logic      out_valid,
  output out_data_t out_data,
  input  logic      out_stall
);

  bk_step_t  step_r, step_nxt, cur;
  logic      out_valid_r, out_free, emit;
  out_data_t out_data_r, res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign emit      = q_valid & out_free;

  always_comb begin
    if (step_r == BK_START) begin
      cur = q_data.marker ? BK_MARK : BK_CODE;
    end else begin
      cur = step_r;
    end
    res      = '0;
    step_nxt = step_r;
    q_pop    = 1'b0;
    case (cur)
      BK_MARK: begin
        res.out_kind  = KIND_BYTE;
        res.code_byte = CODE_MARKER;
        step_nxt      = BK_NODE;
      end
      BK_NODE: begin
        res.out_kind   = KIND_WORD;
        res.word_value = q_data.node;
        step_nxt       = BK_CODE;
      end
      BK_CODE: begin
        res.out_kind    = KIND_BYTE;
        res.code_byte   = q_data.code;
        res.last_result = ~q_data.escape;
        step_nxt        = q_data.escape ? BK_N : BK_START;
      end
      BK_N: begin
        res.out_kind   = KIND_WORD;
        res.word_value = q_data.n;
        step_nxt       = BK_T;
      end
      BK_T: begin
        res.out_kind   = KIND_WORD;
        res.word_value = q_data.t;
        step_nxt       = BK_X;
      end
      BK_X: begin
        res.out_kind    = KIND_WORD;
        res.word_value  = q_data.x;
        res.last_result = 1'b1;
        step_nxt        = BK_START;
      end
      default: begin
        step_nxt = BK_START;
      end
    endcase
    if (emit) begin
      q_pop = res.last_result;
    end else begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= BK_START;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (out_free) begin
        out_valid_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== hw/rtl/index_tuple_delta_encoder.sv =====
// Top level of the index tuple delta encoder: front classifier, plan queue
// and result sequencer. Depends on idte_pkg, idte_front, idte_queue, idte_back.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_data_t (first flag, node, n, t, x)
//   out_     output     out_valid/out_stall out_data_t (kind, byte, word, last)
//   cfg_     input      cfg_valid/cfg_ready format_mode bit
//
// A tuple is classified in the cycle it is accepted; its results leave the
// back one per unstalled cycle, so a tuple gives 1 to 6 results (1 for a
// delta or step byte, 4 for an escape, plus 2 for a marker and node word).
// Sustained rate is one tuple per unstalled cycle when each gives a single
// byte; the back sequencer sets the rate otherwise. in_stall rises when the
// two-entry plan queue is full. Reset is synchronous; it sets format_mode to
// 1 and clears the previous tuple. out_stall holds the output register.
module index_tuple_delta_encoder import idte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_data_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_data_t out_data,
  input  logic      out_stall,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  output logic      cfg_ready
);

  logic  q_wr, q_full, q_valid, q_pop;
  plan_t q_wr_data, q_rd_data;

  idte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_wr      (q_wr),
    .q_data    (q_wr_data),
    .q_full    (q_full)
  );

  idte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data),
    .rd_pop   (q_pop)
  );

  idte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // A transferred marker byte is always followed by the node word.
  a_marker_then_node: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.out_kind == KIND_BYTE &&
     out_data.code_byte == CODE_MARKER && !out_data.last_result)
    |=> (out_valid && out_data.out_kind == KIND_WORD))
    else $error("marker byte not followed by node word");

  // An escape byte that is not last is followed at once by the n word.
  a_escape_then_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.out_kind == KIND_BYTE &&
     out_data.code_byte == CODE_ESCAPE && !out_data.last_result)
    |=> (out_valid && out_data.out_kind == KIND_WORD))
    else $error("escape byte not followed by a word");

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// ===== bench/idte_code_checker.sv =====
// Result checker for the index tuple delta encoder: watches the input, result and
// mode channels, predicts the codes of every accepted tuple and compares them.
// Depends on idte_pkg.
module idte_code_checker import idte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_data_t  in_data,
  input  logic      in_stall,
  input  logic      out_valid,
  input  out_data_t out_data,
  input  logic      out_stall,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  input  logic      cfg_ready,
  output int        mismatch_count,
  output int        open_results
);

  logic               format_mode;
  logic signed [31:0] last_node;
  logic signed [31:0] last_n;
  logic signed [31:0] last_t;
  logic signed [31:0] last_x;
  out_data_t          pending_codes[$];
  int                 results_seen;

  initial mismatch_count = 0;
  initial open_results = 0;
  initial results_seen = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR: result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    end
  endtask

  function automatic out_data_t byte_code(input logic [7:0] code);
    out_data_t r;
    r = '0;
    r.out_kind = KIND_BYTE;
    r.code_byte = code;
    return r;
  endfunction

  function automatic out_data_t word_code(input logic [31:0] value);
    out_data_t r;
    r = '0;
    r.out_kind = KIND_WORD;
    r.word_value = value;
    return r;
  endfunction

  // Works out the codes of one tuple and queues them; differences are taken
  // at 64 bits so they never wrap.
  task automatic predict_codes(input in_data_t item);
    longint    n, t, x, pn, pt, px, delta, limit;
    bit        tag_mode, coded;
    out_data_t seq [6];
    int        cnt;
    out_data_t r;
    n = longint'($signed(item.batch_n));
    t = longint'($signed(item.time_t));
    x = longint'($signed(item.extra_x));
    pn = longint'(last_n);
    pt = longint'(last_t);
    px = longint'(last_x);
    delta = t - pt;
    tag_mode = (format_mode == MODE_TAGGED);
    limit = tag_mode ? 124 : 125;
    coded = 1'b0;
    cnt = 0;
    if (tag_mode && (item.first_of_vector || item.node_id != last_node)) begin
      seq[cnt] = byte_code(CODE_MARKER);
      cnt++;
      seq[cnt] = word_code(item.node_id);
      cnt++;
    end
    if (item.first_of_vector) begin
      if (n == 0 && x == 0 && t > -125 && t < 125) begin
        seq[cnt] = byte_code(item.time_t[7:0]);
        cnt++;
        coded = 1'b1;
      end else if (tag_mode && t == 0 && x == 0 && (n == 0 || n == 1)) begin
        seq[cnt] = byte_code((n == 0) ? CODE_STEP_ZERO : CODE_STEP_ONE);
        cnt++;
        coded = 1'b1;
      end
    end else begin
      if (n == pn && x == px && delta > -limit && delta < limit) begin
        seq[cnt] = byte_code(delta[7:0]);
        cnt++;
        coded = 1'b1;
      end else if (tag_mode && t == pt && x == px && (n == pn || n == pn + 1)) begin
        seq[cnt] = byte_code((n == pn) ? CODE_STEP_ZERO : CODE_STEP_ONE);
        cnt++;
        coded = 1'b1;
      end
    end
    if (!coded) begin
      seq[cnt] = byte_code(CODE_ESCAPE);
      cnt++;
      seq[cnt] = word_code(item.batch_n);
      cnt++;
      seq[cnt] = word_code(item.time_t);
      cnt++;
      seq[cnt] = word_code(item.extra_x);
      cnt++;
    end
    for (int i = 0; i < cnt; i++) begin
      r = seq[i];
      r.last_result = (i == cnt - 1);
      pending_codes.insert(pending_codes.size(), r);
    end
    last_node = item.node_id;
    last_n = item.batch_n;
    last_t = item.time_t;
    last_x = item.extra_x;
  endtask

  always @(posedge clk) begin
    out_data_t want;
    if (!rst_n) begin
      format_mode = MODE_TAGGED;
      last_node = '0;
      last_n = '0;
      last_t = '0;
      last_x = '0;
      pending_codes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        format_mode = cfg_data;
      end
      if (in_valid && !in_stall) begin
        predict_codes(in_data);
      end
      if (out_valid && !out_stall) begin
        if (pending_codes.size() == 0) begin
          report_mismatch("result transfer with no code expected");
        end else begin
          want = pending_codes.pop_front();
          check_field("out_kind", want.out_kind, out_data.out_kind);
          check_field("code_byte", want.code_byte, out_data.code_byte);
          check_field("word_value", want.word_value, out_data.word_value);
          check_field("last_result", want.last_result, out_data.last_result);
        end
        results_seen++;
      end
    end
    open_results <= pending_codes.size();
  end

endmodule

// ===== bench/index_tuple_delta_encoder_tb.sv =====
// Top of the index tuple delta encoder bench: clock, reset, tuple and mode
// stimulus, random result stalls and the verdict.
// Depends on idte_pkg, index_tuple_delta_encoder and idte_code_checker.
module index_tuple_delta_encoder_tb;
  import idte_pkg::*;

  localparam int INT_MAX = 32'sh7fffffff;
  localparam int INT_MIN = 32'sh80000000;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_data_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  out_data_t out_data;
  logic      out_stall = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data = 1'b0;
  logic      cfg_ready;
  int        mismatch_count;
  int        open_results;
  int        send_idle = 0;
  int        recv_idle = 0;

  index_tuple_delta_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready)
  );

  idte_code_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .out_stall      (out_stall),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .cfg_ready      (cfg_ready),
    .mismatch_count (mismatch_count),
    .open_results   (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle);
  end

  function automatic in_data_t make_tuple(input bit first, input int node, input int n,
                                          input int t, input int x);
    in_data_t item;
    item.first_of_vector = first;
    item.node_id = node;
    item.batch_n = n;
    item.time_t = t;
    item.extra_x = x;
    return item;
  endfunction

  // Mostly well-formed vectors built on the previous tuple, with some noise.
  function automatic in_data_t random_tuple(input in_data_t prev);
    in_data_t item;
    int       pick;
    item = prev;
    item.first_of_vector = 1'b0;
    pick = $urandom_range(99);
    if (pick < 45) begin
      item.time_t = prev.time_t + int'($urandom_range(260)) - 130;
    end else if (pick < 60) begin
      item.batch_n = prev.batch_n + int'($urandom_range(3)) - 1;
      if ($urandom_range(9) == 0) item.time_t = prev.time_t + 1;
      if ($urandom_range(9) == 0) item.extra_x = prev.extra_x + 1;
    end else if (pick < 72) begin
      item.first_of_vector = 1'b1;
      item.batch_n = ($urandom_range(9) == 0) ? int'($urandom) : int'($urandom_range(1));
      item.extra_x = ($urandom_range(4) == 0) ? int'($urandom_range(3)) : 0;
      item.time_t = ($urandom_range(2) == 0) ? 0 : int'($urandom_range(260)) - 130;
      if ($urandom_range(3) == 0) item.node_id = $urandom;
    end else if (pick < 82) begin
      item.node_id = ($urandom_range(1) == 0) ? prev.node_id + 1 : int'($urandom);
      item.time_t = prev.time_t + int'($urandom_range(20)) - 10;
    end else begin
      item.first_of_vector = 1'($urandom_range(1));
      item.node_id = $urandom;
      item.batch_n = $urandom;
      item.time_t = $urandom;
      item.extra_x = $urandom;
      if ($urandom_range(3) == 0) item.time_t = $urandom_range(1) ? INT_MAX : INT_MIN;
      if ($urandom_range(3) == 0) item.batch_n = $urandom_range(1) ? INT_MAX : INT_MIN;
    end
    return item;
  endfunction

  task automatic send_tuple(input in_data_t item);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender off until every predicted code has been transferred.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_data_t item;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 33;
    recv_idle = 61;

    // Node-tagged mode out of reset; the first tuple is compared with the
    // zero state.
    send_tuple(make_tuple(0, 0, 0, 5, 0));
    send_tuple(make_tuple(1, 0, 0, 124, 0));
    send_tuple(make_tuple(0, 0, 0, 247, 0));
    send_tuple(make_tuple(0, 0, 0, 371, 0));
    send_tuple(make_tuple(0, 0, 0, 248, 0));
    send_tuple(make_tuple(0, 0, 1, 248, 0));
    send_tuple(make_tuple(0, 0, 1, 248, 0));
    send_tuple(make_tuple(1, 0, 1, 0, 0));
    send_tuple(make_tuple(1, 0, 0, 0, 0));
    send_tuple(make_tuple(1, 0, 0, -125, 0));
    send_tuple(make_tuple(1, 0, 0, -124, 0));
    send_tuple(make_tuple(0, INT_MAX, 0, -124, 0));
    send_tuple(make_tuple(0, INT_MIN, INT_MAX, INT_MIN, INT_MAX));
    send_tuple(make_tuple(0, INT_MIN, INT_MAX, INT_MAX, INT_MAX));
    // An n step across the top of the range wraps and must not count as a step.
    send_tuple(make_tuple(0, INT_MIN, INT_MIN, INT_MAX, INT_MAX));
    send_tuple(make_tuple(0, INT_MIN, INT_MIN, INT_MAX, INT_MAX));

    wait_results_done();
    write_mode(MODE_PLAIN);
    send_tuple(make_tuple(1, 5, 0, -124, 0));
    send_tuple(make_tuple(0, 6, 0, 0, 0));
    send_tuple(make_tuple(0, 6, 0, -124, 0));
    send_tuple(make_tuple(0, 6, 0, 1, 0));
    send_tuple(make_tuple(0, 6, 1, 1, 0));
    send_tuple(make_tuple(1, 6, 1, 0, 0));
    send_tuple(make_tuple(1, -1, -1, -1, -1));
    send_tuple(make_tuple(0, 0, 0, 0, 0));
    item = make_tuple(0, 0, 0, 0, 0);

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle = 33;
          recv_idle = 61;
        end
        1: begin
          send_idle = 61;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      wait_results_done();
      write_mode((seg % 2 == 0) ? MODE_TAGGED : MODE_PLAIN);
      repeat (65) begin
        item = random_tuple(item);
        send_tuple(item);
      end
    end

    wait_results_done();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("simulation failed");
    $finish;
  end

endmodule
